### hw/rtl/spr_pkg.sv
// shared types, constants and arithmetic helpers of the spin precession ensemble
package spr_pkg;

   localparam int MAX_STEPS_DEF = 1024;

   localparam int FIELD_W = 16;
   localparam int SPIN_W  = 32;
   localparam int H_W     = 16;
   localparam int INV_W   = 24;
   localparam int CNT_W   = 11;
   localparam int IDX_W   = 10;
   localparam int ACC_W   = 48;
   localparam int OPA_W   = 38;
   localparam int OPB_W   = 26;
   localparam int PROD_W  = 64;
   localparam int K_W     = 38;
   localparam int KSUM_W  = 42;
   localparam int DOT_W   = 50;
   localparam int CROSS_W = 49;
   localparam int DIV_W   = 38;

   localparam logic [1:0] ACT_RUN   = 2'd0;
   localparam logic [1:0] ACT_READ  = 2'd1;
   localparam logic [1:0] ACT_CLEAR = 2'd2;

   localparam logic [1:0] CSR_STEP_SIZE     = 2'd0;
   localparam logic [1:0] CSR_INVERSE_COUNT = 2'd1;
   localparam logic [1:0] CSR_STEP_COUNT    = 2'd2;

   localparam logic [H_W-1:0]   STEP_SIZE_RST     = 16'd655;
   localparam logic [INV_W-1:0] INVERSE_COUNT_RST = 24'd16777;
   localparam logic [CNT_W-1:0] STEP_COUNT_RST    = 11'd1000;

   localparam logic signed [SPIN_W-1:0] SPIN_ONE = 32'sh2000_0000;

   // divide-by-six offset and clamp: 6*2^35 and 2^35
   localparam logic signed [PROD_W-1:0] DIV_BIAS = 64'sd34359738368;
   localparam logic signed [PROD_W-1:0] DIV_OFF  = 64'sd206158430208;

   localparam logic signed [PROD_W-1:0] ACC_HI = 64'sh0000_7FFF_FFFF_FFFF;
   localparam logic signed [PROD_W-1:0] ACC_LO = -64'sh0000_8000_0000_0000;
   localparam logic signed [PROD_W-1:0] W32_HI = 64'sh0000_0000_7FFF_FFFF;
   localparam logic signed [PROD_W-1:0] W32_LO = -64'sh0000_0000_8000_0000;

   typedef logic [DIV_W-1:0] div_word_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_OUT,
      ST_START,
      ST_ACC,
      ST_WRITE,
      ST_SLOPE,
      ST_ARG,
      ST_DIV,
      ST_DIVWAIT,
      ST_NEXT
   } state_type;

   function automatic logic signed [ACC_W-1:0] sat48(input logic signed [PROD_W-1:0] x);
      logic signed [ACC_W-1:0] r;
      if (x > ACC_HI) begin
         r = ACC_HI[ACC_W-1:0];
      end else if (x < ACC_LO) begin
         r = ACC_LO[ACC_W-1:0];
      end else begin
         r = x[ACC_W-1:0];
      end
      return r;
   endfunction

   function automatic logic signed [SPIN_W-1:0] sat32(input logic signed [PROD_W-1:0] x);
      logic signed [SPIN_W-1:0] r;
      if (x > W32_HI) begin
         r = W32_HI[SPIN_W-1:0];
      end else if (x < W32_LO) begin
         r = W32_LO[SPIN_W-1:0];
      end else begin
         r = x[SPIN_W-1:0];
      end
      return r;
   endfunction

   function automatic logic signed [PROD_W-1:0] rnd24(input logic signed [PROD_W-1:0] p);
      logic signed [PROD_W-1:0] t;
      t = (p + 64'sd8388608) >>> 24;
      return t;
   endfunction

endpackage

### hw/rtl/spr_div6.sv
// three-lane divider by six through reciprocal multiplication, two partial products per lane
module spr_div6 (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  spr_pkg::div_word_type  dividend [3],
   output logic                   done,
   output spr_pkg::div_word_type  quotient [3]
);
   import spr_pkg::*;

   // floor(x / 6) = floor((x >> 1) * ((2^37 + 1) / 3) / 2^37)
   localparam int YW = DIV_W - 1;
   localparam int MW = 18;
   localparam int PW = YW + MW;
   localparam int SW = PW + MW;
   localparam logic [MW-1:0] RECIP_LO = 18'h2AAAB;
   localparam logic [MW-1:0] RECIP_HI = 18'h2AAAA;

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic               half_ff, half_in;
   logic [1:0]         lane_ff, lane_in;
   logic [YW-1:0]      y_ff [3];
   logic [YW-1:0]      y_in [3];
   div_word_type       q_ff [3];
   div_word_type       q_in [3];
   logic [SW-1:0]      acc_ff, acc_in;
   logic [YW-1:0]      ysel;
   logic [PW-1:0]      prod;
   logic [SW-1:0]      total;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      half_in = half_ff;
      lane_in = lane_ff;
      acc_in  = acc_ff;
      ysel    = '0;
      for (int i = 0; i < 3; i++) begin
         y_in[i] = y_ff[i];
         q_in[i] = q_ff[i];
         if (lane_ff == 2'(i)) ysel = y_ff[i];
      end
      prod  = PW'(ysel) * PW'(half_ff ? RECIP_HI : RECIP_LO);
      total = acc_ff + (SW'(prod) << MW);
      if (start) begin
         busy_in = 1'b1;
         half_in = 1'b0;
         lane_in = '0;
         for (int i = 0; i < 3; i++) begin
            y_in[i] = dividend[i][DIV_W-1:1];
         end
      end else if (busy_ff) begin
         if (!half_ff) begin
            acc_in  = SW'(prod);
            half_in = 1'b1;
         end else begin
            for (int i = 0; i < 3; i++) begin
               if (lane_ff == 2'(i)) q_in[i] = DIV_W'(total >> YW);
            end
            half_in = 1'b0;
            lane_in = lane_ff + 1'b1;
            if (lane_ff == 2'd2) begin
               busy_in = 1'b0;
               done_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         half_ff <= 1'b0;
         lane_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         half_ff <= half_in;
         lane_ff <= lane_in;
      end
      acc_ff <= acc_in;
      for (int i = 0; i < 3; i++) begin
         y_ff[i] <= y_in[i];
         q_ff[i] <= q_in[i];
      end
   end

   assign done = done_ff;
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         quotient[i] = q_ff[i];
      end
   end

endmodule

### hw/rtl/spin_precession_rk4_ensemble.sv
// top level: rk4 spin precession with per-step ensemble accumulators
//
//  channel   dir  handshake              payload
//  req       in   req_tvalid/req_tready  tuser action, tdata field_x/y/z, read_index
//  rsp       out  rsp_tvalid/rsp_tready  tdata step_index, mean_x/y/z, mean_energy
//  csr       in   csr_valid/csr_ready    csr_index, csr_data
//
// one time point of a run forms 43 products through the single
// 38x26 multiplier, then a divide by six
// a run computes min(step_count, MAX_STEPS) - 1 time points
// after reset and after a clear beat all MAX_STEPS entries of the stores are swept to zero
// req_tready is low while an item is in work; a pending result holds only readout
module spin_precession_rk4_ensemble #(
   parameter int MAX_STEPS = spr_pkg::MAX_STEPS_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [1:0]    req_tuser,    // action
   input  logic [63:0]   req_tdata,    // field_x, field_y, field_z, read_index
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [143:0]  rsp_tdata,    // step_index, mean_x, mean_y, mean_z, mean_energy
   input  logic          csr_valid,
   output logic          csr_ready,
   input  logic [1:0]    csr_index,
   input  logic [23:0]   csr_data
);
   import spr_pkg::*;

   localparam int AW = $clog2(MAX_STEPS);
   localparam int TW = (AW + 1 > CNT_W) ? AW + 2 : CNT_W + 1;
   localparam int RW = (AW > IDX_W) ? AW + 1 : IDX_W + 1;

   state_type state_ff, state_in;

   logic [H_W-1:0]   step_size_ff, step_size_in;
   logic [INV_W-1:0] inverse_count_ff, inverse_count_in;
   logic [CNT_W-1:0] step_count_ff, step_count_in;

   logic [TW-1:0] t_ff, t_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic [2:0]    op_ff, op_in;
   logic          ph_ff, ph_in;
   logic [1:0]    stage_ff, stage_in;
   logic [1:0]    comp_ff, comp_in;
   logic [1:0]    sub_ff, sub_in;
   logic [IDX_W-1:0] ridx_ff, ridx_in;

   logic signed [FIELD_W-1:0] b_ff [3];
   logic signed [FIELD_W-1:0] b_in [3];
   logic signed [SPIN_W-1:0]  s_ff [3];
   logic signed [SPIN_W-1:0]  s_in [3];
   logic signed [SPIN_W-1:0]  arg_ff [3];
   logic signed [SPIN_W-1:0]  arg_in [3];
   logic signed [K_W-1:0]     kcur_ff [3];
   logic signed [K_W-1:0]     kcur_in [3];
   logic signed [KSUM_W-1:0]  ksum_ff [3];
   logic signed [KSUM_W-1:0]  ksum_in [3];
   logic signed [ACC_W-1:0]   mnew_ff [3];
   logic signed [ACC_W-1:0]   mnew_in [3];
   logic signed [ACC_W-1:0]   enew_ff, enew_in;
   logic signed [DOT_W-1:0]   dot_ff, dot_in;
   logic signed [CROSS_W-1:0] c_ff, c_in;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [143:0]  rsp_data_ff, rsp_data_in;

   logic signed [ACC_W-1:0] mem_m0 [MAX_STEPS];
   logic signed [ACC_W-1:0] mem_m1 [MAX_STEPS];
   logic signed [ACC_W-1:0] mem_m2 [MAX_STEPS];
   logic signed [ACC_W-1:0] mem_e  [MAX_STEPS];
   logic signed [ACC_W-1:0] rd_m_ff [3];
   logic signed [ACC_W-1:0] rd_e_ff;

   logic                    mem_we;
   logic [AW-1:0]           mem_waddr;
   logic [AW-1:0]           rd_addr;
   logic signed [ACC_W-1:0] wd_m [3];
   logic signed [ACC_W-1:0] wd_e;

   logic                req_fire;
   logic [TW-1:0]       steps_w;
   logic [RW-1:0]       req_idx_ext;
   logic [RW-1:0]       ridx_ext;
   logic                rok;
   logic signed [OPA_W-1:0] opa;
   logic signed [OPB_W-1:0] opb;
   logic signed [DOT_W:0]   dot_rnd;
   logic signed [CROSS_W:0] c_rnd;
   logic signed [PROD_W-1:0] kwide;
   logic signed [K_W-1:0]   kval;
   logic signed [PROD_W-1:0] addend;
   logic signed [PROD_W-1:0] xdiv;
   logic                    div_start;
   logic                    div_done;
   div_word_type            div_x [3];
   div_word_type            div_q [3];
   logic signed [SPIN_W-1:0] rd_sat [4];

   assign req_fire    = req_tvalid && req_tready;
   assign csr_ready   = 1'b1;
   assign steps_w     = (TW'(step_count_ff) < TW'(MAX_STEPS)) ? TW'(step_count_ff)
                                                                : TW'(MAX_STEPS);
   assign req_idx_ext = RW'(req_tdata[57:48]);
   assign ridx_ext    = RW'(ridx_ff);
   assign rok         = ridx_ext < RW'(MAX_STEPS);
   assign dot_rnd     = ((DOT_W + 1)'(dot_ff) + (DOT_W + 1)'(16384)) >>> 15;
   assign c_rnd       = ((CROSS_W + 1)'(c_ff) + (CROSS_W + 1)'(2048)) >>> 12;
   assign kwide       = (prod_ff + 64'sd32768) >>> 16;
   assign kval        = kwide[K_W-1:0];

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == AW'(MAX_STEPS - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_fire) begin
               unique case (req_tuser)
                  ACT_RUN:   state_in = (steps_w < TW'(2)) ? ST_IDLE : ST_START;
                  ACT_READ:  state_in = ST_OUT;
                  ACT_CLEAR: state_in = ST_CLEAR;
                  default:   state_in = ST_IDLE;
               endcase
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) state_in = ST_IDLE;
         end
         ST_START: state_in = ST_ACC;
         ST_ACC: begin
            if (ph_ff && op_ff == 3'd6) state_in = ST_WRITE;
         end
         ST_WRITE: state_in = ST_SLOPE;
         ST_SLOPE: begin
            if (ph_ff && sub_ff == 2'd2 && comp_ff == 2'd2) begin
               state_in = (stage_ff == 2'd3) ? ST_DIV : ST_ARG;
            end
         end
         ST_ARG:  state_in = ST_SLOPE;
         ST_DIV:  state_in = ST_DIVWAIT;
         ST_DIVWAIT: begin
            if (div_done) state_in = ST_NEXT;
         end
         ST_NEXT: state_in = (t_ff + TW'(2) < steps_w) ? ST_START : ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_tready = (state_ff == ST_IDLE);
      mem_we     = (state_ff == ST_CLEAR) || (state_ff == ST_WRITE);
      mem_waddr  = (state_ff == ST_CLEAR) ? clr_ff : t_ff[AW-1:0];
      div_start  = (state_ff == ST_DIV);
      if (state_ff == ST_IDLE) begin
         rd_addr = req_idx_ext[AW-1:0];
      end else if (state_ff == ST_OUT) begin
         rd_addr = ridx_ext[AW-1:0];
      end else begin
         rd_addr = t_ff[AW-1:0];
      end
      for (int i = 0; i < 3; i++) begin
         wd_m[i] = (state_ff == ST_CLEAR) ? '0 : mnew_ff[i];
      end
      wd_e = (state_ff == ST_CLEAR) ? '0 : enew_ff;
   end

   // multiplier operands
   always_comb begin
      opa = '0;
      opb = '0;
      if (state_ff == ST_ACC) begin
         case (op_ff)
            3'd0: begin opa = OPA_W'(s_ff[0]); opb = OPB_W'(b_ff[0]); end
            3'd1: begin opa = OPA_W'(s_ff[1]); opb = OPB_W'(b_ff[1]); end
            3'd2: begin opa = OPA_W'(s_ff[2]); opb = OPB_W'(b_ff[2]); end
            3'd3: begin opa = OPA_W'(dot_rnd); opb = $signed({2'b00, inverse_count_ff}); end
            3'd4: begin opa = OPA_W'(s_ff[0]); opb = $signed({2'b00, inverse_count_ff}); end
            3'd5: begin opa = OPA_W'(s_ff[1]); opb = $signed({2'b00, inverse_count_ff}); end
            default: begin opa = OPA_W'(s_ff[2]); opb = $signed({2'b00, inverse_count_ff}); end
         endcase
      end else if (sub_ff == 2'd2) begin
         opa = OPA_W'(c_rnd);
         opb = $signed({10'd0, step_size_ff});
      end else begin
         // cross term b[p]*a[q] then b[q]*a[p]
         case (comp_ff)
            2'd0: begin
               opa = OPA_W'((sub_ff == 2'd0) ? arg_ff[2] : arg_ff[1]);
               opb = OPB_W'((sub_ff == 2'd0) ? b_ff[1] : b_ff[2]);
            end
            2'd1: begin
               opa = OPA_W'((sub_ff == 2'd0) ? arg_ff[0] : arg_ff[2]);
               opb = OPB_W'((sub_ff == 2'd0) ? b_ff[2] : b_ff[0]);
            end
            default: begin
               opa = OPA_W'((sub_ff == 2'd0) ? arg_ff[1] : arg_ff[0]);
               opb = OPB_W'((sub_ff == 2'd0) ? b_ff[0] : b_ff[1]);
            end
         endcase
      end
      prod_in = PROD_W'(opa) * PROD_W'(opb);
   end

   // datapath and counters
   always_comb begin
      step_size_in     = step_size_ff;
      inverse_count_in = inverse_count_ff;
      step_count_in    = step_count_ff;
      t_in     = t_ff;
      clr_in   = clr_ff;
      op_in    = op_ff;
      ph_in    = ph_ff;
      stage_in = stage_ff;
      comp_in  = comp_ff;
      sub_in   = sub_ff;
      ridx_in  = ridx_ff;
      dot_in   = dot_ff;
      c_in     = c_ff;
      enew_in  = enew_ff;
      addend   = '0;
      xdiv     = '0;
      for (int i = 0; i < 3; i++) begin
         b_in[i]    = b_ff[i];
         s_in[i]    = s_ff[i];
         arg_in[i]  = arg_ff[i];
         kcur_in[i] = kcur_ff[i];
         ksum_in[i] = ksum_ff[i];
         mnew_in[i] = mnew_ff[i];
         div_x[i]   = '0;
      end

      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_STEP_SIZE:     step_size_in     = csr_data[H_W-1:0];
            CSR_INVERSE_COUNT: inverse_count_in = csr_data;
            CSR_STEP_COUNT:    step_count_in    = csr_data[CNT_W-1:0];
            default: ;
         endcase
      end

      for (int i = 0; i < 3; i++) begin
         xdiv = PROD_W'(ksum_ff[i]) + 64'sd3;
         if (xdiv > DIV_BIAS - 64'sd1) xdiv = DIV_BIAS - 64'sd1;
         if (xdiv < -DIV_BIAS) xdiv = -DIV_BIAS;
         xdiv = xdiv + DIV_OFF;
         div_x[i] = xdiv[DIV_W-1:0];
      end

      case (state_ff)
         ST_CLEAR: clr_in = clr_ff + 1'b1;
         ST_IDLE: begin
            if (req_fire) begin
               if (req_tuser == ACT_RUN) begin
                  b_in[0] = req_tdata[15:0];
                  b_in[1] = req_tdata[31:16];
                  b_in[2] = req_tdata[47:32];
                  s_in[0] = '0;
                  s_in[1] = '0;
                  s_in[2] = SPIN_ONE;
                  t_in    = '0;
               end else if (req_tuser == ACT_READ) begin
                  ridx_in = req_tdata[57:48];
               end else if (req_tuser == ACT_CLEAR) begin
                  clr_in = '0;
               end
            end
         end
         ST_START: begin
            op_in = '0;
            ph_in = 1'b0;
         end
         ST_ACC: begin
            ph_in = ~ph_ff;
            if (ph_ff) begin
               op_in = op_ff + 1'b1;
               case (op_ff)
                  3'd0: dot_in = prod_ff[DOT_W-1:0];
                  3'd1, 3'd2: dot_in = dot_ff + prod_ff[DOT_W-1:0];
                  3'd3: enew_in = sat48(PROD_W'(rd_e_ff) + rnd24(prod_ff));
                  3'd4: mnew_in[0] = sat48(PROD_W'(rd_m_ff[0]) + rnd24(prod_ff));
                  3'd5: mnew_in[1] = sat48(PROD_W'(rd_m_ff[1]) + rnd24(prod_ff));
                  default: mnew_in[2] = sat48(PROD_W'(rd_m_ff[2]) + rnd24(prod_ff));
               endcase
            end
         end
         ST_WRITE: begin
            for (int i = 0; i < 3; i++) arg_in[i] = s_ff[i];
            stage_in = '0;
            comp_in  = '0;
            sub_in   = '0;
            ph_in    = 1'b0;
         end
         ST_SLOPE: begin
            ph_in = ~ph_ff;
            if (ph_ff) begin
               case (sub_ff)
                  2'd0: begin
                     c_in   = prod_ff[CROSS_W-1:0];
                     sub_in = 2'd1;
                  end
                  2'd1: begin
                     c_in   = c_ff - prod_ff[CROSS_W-1:0];
                     sub_in = 2'd2;
                  end
                  default: begin
                     sub_in  = '0;
                     comp_in = (comp_ff == 2'd2) ? 2'd0 : comp_ff + 1'b1;
                     for (int i = 0; i < 3; i++) begin
                        if (comp_ff == 2'(i)) begin
                           kcur_in[i] = kval;
                           if (stage_ff == 2'd0) begin
                              ksum_in[i] = KSUM_W'(kval);
                           end else if (stage_ff == 2'd3) begin
                              ksum_in[i] = ksum_ff[i] + KSUM_W'(kval);
                           end else begin
                              ksum_in[i] = ksum_ff[i] + (KSUM_W'(kval) <<< 1);
                           end
                        end
                     end
                  end
               endcase
            end
         end
         ST_ARG: begin
            for (int i = 0; i < 3; i++) begin
               if (stage_ff == 2'd2) begin
                  addend = PROD_W'(kcur_ff[i]);
               end else begin
                  addend = (PROD_W'(kcur_ff[i]) + 64'sd1) >>> 1;
               end
               arg_in[i] = sat32(PROD_W'(s_ff[i]) + addend);
            end
            stage_in = stage_ff + 1'b1;
         end
         ST_DIVWAIT: begin
            if (div_done) begin
               for (int i = 0; i < 3; i++) begin
                  s_in[i] = sat32(PROD_W'(s_ff[i]) + $signed({26'd0, div_q[i]}) - DIV_BIAS);
               end
            end
         end
         ST_NEXT: t_in = t_ff + 1'b1;
         default: ;
      endcase
   end

   // result register
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         rd_sat[i] = sat32(PROD_W'(rd_m_ff[i]));
      end
      rd_sat[3]    = sat32(PROD_W'(rd_e_ff));
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (state_ff == ST_OUT && (!rsp_valid_ff || rsp_tready)) begin
         rsp_valid_in = 1'b1;
         if (rok) begin
            rsp_data_in = {6'd0, rd_sat[3], rd_sat[2], rd_sat[1], rd_sat[0], ridx_ff};
         end else begin
            rsp_data_in = {134'd0, ridx_ff};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_CLEAR;
         clr_ff           <= '0;
         t_ff             <= '0;
         op_ff            <= '0;
         ph_ff            <= 1'b0;
         stage_ff         <= '0;
         comp_ff          <= '0;
         sub_ff           <= '0;
         rsp_valid_ff     <= 1'b0;
         step_size_ff     <= STEP_SIZE_RST;
         inverse_count_ff <= INVERSE_COUNT_RST;
         step_count_ff    <= STEP_COUNT_RST;
      end else begin
         state_ff         <= state_in;
         clr_ff           <= clr_in;
         t_ff             <= t_in;
         op_ff            <= op_in;
         ph_ff            <= ph_in;
         stage_ff         <= stage_in;
         comp_ff          <= comp_in;
         sub_ff           <= sub_in;
         rsp_valid_ff     <= rsp_valid_in;
         step_size_ff     <= step_size_in;
         inverse_count_ff <= inverse_count_in;
         step_count_ff    <= step_count_in;
      end
      ridx_ff     <= ridx_in;
      dot_ff      <= dot_in;
      c_ff        <= c_in;
      enew_ff     <= enew_in;
      prod_ff     <= prod_in;
      rsp_data_ff <= rsp_data_in;
      for (int i = 0; i < 3; i++) begin
         b_ff[i]    <= b_in[i];
         s_ff[i]    <= s_in[i];
         arg_ff[i]  <= arg_in[i];
         kcur_ff[i] <= kcur_in[i];
         ksum_ff[i] <= ksum_in[i];
         mnew_ff[i] <= mnew_in[i];
      end
   end

   // accumulator stores
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_m0[mem_waddr] <= wd_m[0];
         mem_m1[mem_waddr] <= wd_m[1];
         mem_m2[mem_waddr] <= wd_m[2];
         mem_e[mem_waddr]  <= wd_e;
      end
      rd_m_ff[0] <= mem_m0[rd_addr];
      rd_m_ff[1] <= mem_m1[rd_addr];
      rd_m_ff[2] <= mem_m2[rd_addr];
      rd_e_ff    <= mem_e[rd_addr];
   end

   spr_div6 u_div6 (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_x),
      .done     (div_done),
      .quotient (div_q)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef SYNTHESIS
   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_OUT))
      else $error("result raised outside readout");
   a_div_done_wait: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIVWAIT))
      else $error("divider finished while sequencer not waiting");
   a_step_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SLOPE) |-> (t_ff + TW'(1) < steps_w))
      else $error("time point beyond step count");
   a_sweep_after_reset: assert property (@(posedge clock)
      $fell(reset) |-> !req_tready)
      else $error("ready before store sweep");
`endif

endmodule
